// ===== hw/rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int THREAD_SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_EXIT   = 2'd2,
    OP_REAP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_INVALID_ARGUMENT = 3'd1,
    ST_INVALID_STATE    = 3'd2,
    ST_NO_MEMORY        = 3'd3,
    ST_EMPTY            = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/rrts_if.sv =====
`timescale 1ns / 1ps

interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] tick_delta;

  modport source(output valid, output opcode, output tick_delta, input ready);
  modport sink(input valid, input opcode, input tick_delta, output ready);
endinterface

interface rrts_out_if #(
  parameter int ID_W = $clog2(rrts_pkg::THREAD_SLOTS_DEF + 1)
);
  logic            valid;
  logic            ready;
  logic [2:0]      status;
  logic [ID_W-1:0] running_thread;
  logic [ID_W-1:0] thread_out;
  logic            switched;

  modport source(output valid, output status, output running_thread,
                 output thread_out, output switched, input ready);
  modport sink(input valid, input status, input running_thread,
               input thread_out, input switched, output ready);
endinterface

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_ch     sink       opcode, tick_delta
// out_ch    source     status, running_thread, thread_out, switched
//
// One word is in work at a time: accept, search, update, then the result word.
// A create searches the slot map for a free slot, eight slots per cycle, lowest
// slot first; every other operation passes the search state without searching.
// Reset clears the queue pointers, counts and flags and marks every slot free.
// A stalled result word holds in_ch.ready low until out_ch takes it.

module round_robin_thread_scheduler #(
  parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);
  import rrts_pkg::*;

  localparam int ID_W = $clog2(THREAD_SLOTS + 1);

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic            in_ready;
  logic            out_valid;
  logic [2:0]      status;
  logic [ID_W-1:0] running_thread;
  logic [ID_W-1:0] thread_out;
  logic            switched;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rrts_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (in_ch.opcode),
    .tick_delta     (in_ch.tick_delta),
    .status         (status),
    .running_thread (running_thread),
    .thread_out     (thread_out),
    .switched       (switched)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = status;
  assign out_ch.running_thread = running_thread;
  assign out_ch.thread_out     = thread_out;
  assign out_ch.switched       = switched;

endmodule

// ===== hw/rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps

module rrts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rrts_pkg::dp_cmd_t cmd,
  input  rrts_pkg::dp_sts_t sts
);
  import rrts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    out_valid   = (state == S_OUT);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.scan    = (state == S_SCAN);
    cmd.exec    = (state == S_EXEC);
  end

endmodule

// ===== hw/rtl/rrts_dp.sv =====
`timescale 1ns / 1ps

module rrts_dp #(
  parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF,
  localparam int ID_W = $clog2(THREAD_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  rrts_pkg::dp_cmd_t cmd,
  output rrts_pkg::dp_sts_t sts,
  input  logic [1:0]        opcode,
  input  logic [15:0]       tick_delta,
  output logic [2:0]        status,
  output logic [ID_W-1:0]   running_thread,
  output logic [ID_W-1:0]   thread_out,
  output logic              switched
);
  import rrts_pkg::*;

  localparam int SW     = $clog2(THREAD_SLOTS);
  localparam int CW     = ID_W;
  localparam int GROUPS = (THREAD_SLOTS + 7) / 8;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [ID_W-1:0] ready_mem  [THREAD_SLOTS];
  logic [ID_W-1:0] exited_mem [THREAD_SLOTS];
  logic [ID_W-1:0] ready_rd;
  logic [ID_W-1:0] exited_rd;

  logic [SW-1:0]           rq_head, rq_head_next;
  logic [CW-1:0]           ready_count, ready_count_next;
  logic [SW-1:0]           xq_head, xq_head_next;
  logic [CW-1:0]           exited_count, exited_count_next;
  logic [THREAD_SLOTS-1:0] free_slots, free_slots_next;
  logic [ID_W-1:0]         current_thread, current_thread_next;
  logic                    idle_saved, idle_saved_next;
  logic                    fatal_flag, fatal_flag_next;

  op_t           op_code;
  logic          tick_zero;
  logic [GW-1:0] scan_grp;
  logic          found;
  logic [SW-1:0] found_slot;

  status_t         res_status;
  logic [ID_W-1:0] res_running;
  logic [ID_W-1:0] res_thread;
  logic            res_switched;

  // Free-slot search, eight slots per cycle, lowest slot first.
  logic [GROUPS*8-1:0] free_pad;
  logic [7:0]          grp_bits;
  logic                grp_hit;
  logic [2:0]          grp_pos;
  logic [GW+2:0]       grp_slot;

  assign free_pad = (GROUPS * 8)'(free_slots);
  assign grp_bits = free_pad[8 * scan_grp +: 8];
  assign grp_slot = {scan_grp, grp_pos};

  always_comb begin
    grp_hit = 1'b0;
    grp_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_bits[i]) begin
        grp_hit = 1'b1;
        grp_pos = 3'(i);
      end
    end
  end

  assign sts.scan_done = (op_code != OP_CREATE) || found || grp_hit ||
                         (scan_grp == GW'(GROUPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_code   <= op_t'(opcode);
      tick_zero <= (tick_delta == 16'd0);
      scan_grp  <= '0;
      found     <= 1'b0;
    end else if (cmd.scan) begin
      if (!found && grp_hit) begin
        found      <= 1'b1;
        found_slot <= grp_slot[SW-1:0];
      end
      if (!sts.scan_done) scan_grp <= scan_grp + 1'b1;
    end
  end

  // Queue tail positions and head increments.
  logic [CW:0]   r_sum, x_sum;
  logic [SW-1:0] r_tail, x_tail, r_head_inc, x_head_inc;
  logic          r_full, x_full;

  assign r_sum  = (CW + 1)'(rq_head) + (CW + 1)'(ready_count);
  assign x_sum  = (CW + 1)'(xq_head) + (CW + 1)'(exited_count);
  assign r_tail = (r_sum >= (CW + 1)'(THREAD_SLOTS)) ?
                  SW'(r_sum - (CW + 1)'(THREAD_SLOTS)) : SW'(r_sum);
  assign x_tail = (x_sum >= (CW + 1)'(THREAD_SLOTS)) ?
                  SW'(x_sum - (CW + 1)'(THREAD_SLOTS)) : SW'(x_sum);
  assign r_head_inc = (rq_head == SW'(THREAD_SLOTS - 1)) ? '0 : rq_head + 1'b1;
  assign x_head_inc = (xq_head == SW'(THREAD_SLOTS - 1)) ? '0 : xq_head + 1'b1;
  assign r_full = (ready_count == CW'(THREAD_SLOTS));
  assign x_full = (exited_count == CW'(THREAD_SLOTS));

  logic            r_we, x_we;
  logic [ID_W-1:0] r_wdata;
  status_t         st_n;
  logic [ID_W-1:0] made;

  always_comb begin
    rq_head_next        = rq_head;
    ready_count_next    = ready_count;
    xq_head_next        = xq_head;
    exited_count_next   = exited_count;
    free_slots_next     = free_slots;
    current_thread_next = current_thread;
    idle_saved_next     = idle_saved;
    fatal_flag_next     = fatal_flag;
    r_we                = 1'b0;
    x_we                = 1'b0;
    r_wdata             = '0;
    st_n                = ST_OK;
    made                = '0;

    if (op_code == OP_TICK && tick_zero) begin
      st_n = ST_INVALID_ARGUMENT;
    end else if (fatal_flag) begin
      st_n = ST_INVALID_STATE;
    end else begin
      unique case (op_code)
        OP_CREATE: begin
          if (found) begin
            free_slots_next[found_slot] = 1'b0;
            made = ID_W'(found_slot) + 1'b1;
            if (!r_full) begin
              r_we             = 1'b1;
              r_wdata          = made;
              ready_count_next = ready_count + 1'b1;
            end
          end else begin
            st_n = ST_NO_MEMORY;
          end
        end
        OP_TICK: begin
          if (ready_count != '0) begin
            rq_head_next        = r_head_inc;
            current_thread_next = ready_rd;
            if (current_thread != '0) begin
              r_we    = 1'b1;
              r_wdata = current_thread;
            end else begin
              ready_count_next = ready_count - 1'b1;
              idle_saved_next  = 1'b1;
            end
          end
        end
        OP_EXIT: begin
          if (current_thread == '0) begin
            fatal_flag_next = 1'b1;
            st_n            = ST_INVALID_STATE;
          end else begin
            if (!x_full) begin
              x_we              = 1'b1;
              exited_count_next = exited_count + 1'b1;
            end
            if (ready_count != '0) begin
              rq_head_next        = r_head_inc;
              ready_count_next    = ready_count - 1'b1;
              current_thread_next = ready_rd;
            end else begin
              current_thread_next = '0;
            end
          end
        end
        OP_REAP: begin
          if (current_thread != '0) begin
            st_n = ST_INVALID_STATE;
          end else if (exited_count == '0) begin
            st_n = ST_EMPTY;
          end else begin
            xq_head_next      = x_head_inc;
            exited_count_next = exited_count - 1'b1;
            made              = exited_rd;
            if (exited_rd != '0 && exited_rd <= ID_W'(THREAD_SLOTS)) begin
              free_slots_next[SW'(exited_rd - 1'b1)] = 1'b1;
            end
          end
        end
        default: st_n = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && r_we) ready_mem[r_tail] <= r_wdata;
    if (cmd.exec && x_we) exited_mem[x_tail] <= current_thread;
    ready_rd  <= ready_mem[rq_head];
    exited_rd <= exited_mem[xq_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_head        <= '0;
      ready_count    <= '0;
      xq_head        <= '0;
      exited_count   <= '0;
      free_slots     <= '1;
      current_thread <= '0;
      idle_saved     <= 1'b0;
      fatal_flag     <= 1'b0;
    end else if (cmd.exec) begin
      rq_head        <= rq_head_next;
      ready_count    <= ready_count_next;
      xq_head        <= xq_head_next;
      exited_count   <= exited_count_next;
      free_slots     <= free_slots_next;
      current_thread <= current_thread_next;
      idle_saved     <= idle_saved_next;
      fatal_flag     <= fatal_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status   <= st_n;
      res_running  <= current_thread_next;
      res_thread   <= made;
      res_switched <= (current_thread_next != current_thread);
    end
  end

  assign status         = res_status;
  assign running_thread = res_running;
  assign thread_out     = res_thread;
  assign switched       = res_switched;

endmodule

// ===== hw/rtl/rrts_check.sv =====
`timescale 1ns / 1ps

module rrts_check #(
  parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF,
  localparam int ID_W = $clog2(THREAD_SLOTS + 1)
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [2:0]      status,
  input logic [ID_W-1:0] running_thread,
  input logic [ID_W-1:0] thread_out,
  input logic            switched
);
  import rrts_pkg::*;

  // A new word is never taken while a result word is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an accept");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(running_thread) &&
       $stable(thread_out) && $stable(switched)))
    else $error("stalled result word changed");

  // A failed operation neither switches threads nor reports an ID.
  a_error_no_effect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (!switched && thread_out == '0))
    else $error("error result carries a switch or an ID");

endmodule

bind round_robin_thread_scheduler rrts_check #(
  .THREAD_SLOTS (THREAD_SLOTS)
) u_rrts_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .running_thread (out_ch.running_thread),
  .thread_out     (out_ch.thread_out),
  .switched       (out_ch.switched)
);
